### src/batch_balance_planner_top_macros.svh
// Assertion macros shared by the checker of the batch balance planner.
`ifndef BATCH_BALANCE_PLANNER_TOP_MACROS_SVH
`define BATCH_BALANCE_PLANNER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bbp_pkg.sv
// Shared types and constants of the batch balance planner.
`timescale 1ns / 1ps

package bbp_pkg;

    localparam int IN_SIZE_W = 16;
    localparam int AMT_W     = 16;
    localparam int ID_W      = 3;
    localparam int STATUS_W  = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_XFER    = 3'd0;
    localparam status_t ST_NOBAL   = 3'd1;
    localparam status_t ST_SHORT   = 3'd2;
    localparam status_t ST_SRC_MT  = 3'd3;
    localparam status_t ST_TOOMANY = 3'd4;

    // Control of the ranking chain: shift pulls every held entry one cell
    // towards the head, clr empties the whole chain.
    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctl_t;

endpackage

### src/batch_balance_planner_top.sv
// Top level of the batch balance planner: loading, ranking chain, divider and planner.
// Device sizes are taken one beat per cycle while a set is loading.
// After the final beat the ranking chain settles and the divider works out the quota; a status
// result or the first plan step follows when the wait counter and the divider are done.
// A plan gives one transfer per cycle while the output is free; moving the source gives none.
// Reset (aresetn low at a clock edge) empties the set, the chain and the result register.
`timescale 1ns / 1ps

module batch_balance_planner_top #(
    parameter int MAX_DEVICES = 8,
    parameter int SIZE_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bbp_pkg::IN_SIZE_W-1:0] s_device_size,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bbp_pkg::STATUS_W-1:0]  m_status,
    output logic [bbp_pkg::ID_W-1:0]      m_src_device,
    output logic [bbp_pkg::ID_W-1:0]      m_dst_device,
    output logic [bbp_pkg::AMT_W-1:0]     m_amount,
    output logic                          m_last_result
);
    import bbp_pkg::*;

    // Only the low SIZE_BITS bits of a size beat count, and never more than the port.
    localparam int EFF_W  = (SIZE_BITS < IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;
    localparam int N      = MAX_DEVICES;
    localparam int IDX_W  = $clog2(N);
    localparam int CNT_W  = $clog2(N + 1);
    localparam int TOT_W  = EFF_W + CNT_W;
    localparam int WAIT_N = N + 1;
    localparam int WAIT_W = $clog2(WAIT_N + 1);

    // Loading takes beats, waiting lets the chain and the divider finish,
    // planning walks the ranked sources and the empty devices.
    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_WAIT = 3'b010,
        S_PLAN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  dev_cnt_reg, dev_cnt_next;
    logic [CNT_W-1:0]  empty_cnt_reg, empty_cnt_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              ovf_reg, ovf_next;
    logic [WAIT_W-1:0] wait_cnt_reg, wait_cnt_next;

    // Device numbers of the empty devices, in arrival order, popped from the front.
    logic [ID_W-1:0]   empty_id_reg [N];
    logic [ID_W-1:0]   empty_id_next [N];

    // Current source of the plan, taken from the head of the ranking chain.
    logic [EFF_W-1:0]  src_size_reg, src_size_next;
    logic              src_hi_reg, src_hi_next;
    logic [ID_W-1:0]   src_id_reg, src_id_next;
    logic [CNT_W-1:0]  src_pos_reg, src_pos_next;
    logic [CNT_W-1:0]  full_reg, full_next;
    logic [CNT_W-1:0]  dst_left_reg, dst_left_next;
    logic              skip_reg, skip_next;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [ID_W-1:0]   m_src_reg, m_src_next;
    logic [ID_W-1:0]   m_dst_reg, m_dst_next;
    logic [AMT_W-1:0]  m_amount_reg, m_amount_next;
    logic              m_last_reg, m_last_next;

    logic              acc;
    logic              stored;
    logic [EFF_W-1:0]  size_eff;
    logic              out_free;
    logic              emit;
    cell_ctl_t         chain_ctl;
    logic              div_start;
    logic [TOT_W-1:0]  div_quo;
    logic              div_done;
    logic [EFF_W-1:0]  quota;
    logic [EFF_W:0]    src_diff;
    logic              src_low;

    // Ranking chain wiring.
    logic              pass_v    [N];
    logic [EFF_W-1:0]  pass_size [N];
    logic [IDX_W-1:0]  pass_idx  [N];
    logic              held_v    [N];
    logic [EFF_W-1:0]  held_size [N];
    logic [IDX_W-1:0]  held_idx  [N];
    logic              ins_v;

    assign s_ready  = (state_reg == S_LOAD);
    assign acc      = s_valid && s_ready;
    assign size_eff = EFF_W'(s_device_size);
    assign stored   = (dev_cnt_reg < CNT_W'(N));
    assign out_free = !m_valid_reg || m_ready;
    assign quota    = div_quo[EFF_W-1:0];

    // Empty devices never act as sources, so only non-empty sizes enter the chain.
    assign ins_v = acc && stored && (size_eff != '0);

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            logic              c_in_v;
            logic [EFF_W-1:0]  c_in_size;
            logic [IDX_W-1:0]  c_in_idx;
            logic              c_nxt_v;
            logic [EFF_W-1:0]  c_nxt_size;
            logic [IDX_W-1:0]  c_nxt_idx;

            if (gi == 0) begin : g_head
                assign c_in_v    = ins_v;
                assign c_in_size = size_eff;
                assign c_in_idx  = dev_cnt_reg[IDX_W-1:0];
            end else begin : g_body
                assign c_in_v    = pass_v[gi-1];
                assign c_in_size = pass_size[gi-1];
                assign c_in_idx  = pass_idx[gi-1];
            end

            if (gi == N - 1) begin : g_tail
                assign c_nxt_v    = 1'b0;
                assign c_nxt_size = '0;
                assign c_nxt_idx  = '0;
            end else begin : g_mid
                assign c_nxt_v    = held_v[gi+1];
                assign c_nxt_size = held_size[gi+1];
                assign c_nxt_idx  = held_idx[gi+1];
            end

            bbp_cell #(
                .SIZE_W (EFF_W),
                .IDX_W  (IDX_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (chain_ctl),
                .in_v      (c_in_v),
                .in_size   (c_in_size),
                .in_idx    (c_in_idx),
                .nxt_v     (c_nxt_v),
                .nxt_size  (c_nxt_size),
                .nxt_idx   (c_nxt_idx),
                .pass_v    (pass_v[gi]),
                .pass_size (pass_size[gi]),
                .pass_idx  (pass_idx[gi]),
                .held_v    (held_v[gi]),
                .held_size (held_size[gi]),
                .held_idx  (held_idx[gi])
            );
        end
    endgenerate

    // The quota is the set total divided by the device count, started on the final beat.
    bbp_div #(
        .NUM_W (TOT_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (dev_cnt_next),
        .quotient (div_quo),
        .done     (div_done)
    );

    // A source that once went below zero stays above any quota, as a huge count would.
    assign src_diff = {1'b0, src_size_reg} - {1'b0, quota};
    assign src_low  = !src_hi_reg && (src_size_reg <= quota);

    always_comb begin
        state_next     = state_reg;
        dev_cnt_next   = dev_cnt_reg;
        empty_cnt_next = empty_cnt_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        wait_cnt_next  = wait_cnt_reg;
        empty_id_next  = empty_id_reg;
        src_size_next  = src_size_reg;
        src_hi_next    = src_hi_reg;
        src_id_next    = src_id_reg;
        src_pos_next   = src_pos_reg;
        full_next      = full_reg;
        dst_left_next  = dst_left_reg;
        skip_next      = skip_reg;
        chain_ctl      = '0;
        div_start      = 1'b0;
        emit           = 1'b0;
        m_status_next  = m_status_reg;
        m_src_next     = m_src_reg;
        m_dst_next     = m_dst_reg;
        m_amount_next  = m_amount_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            S_LOAD: begin
                if (acc) begin
                    if (stored) begin
                        dev_cnt_next = dev_cnt_reg + 1'b1;
                        total_next   = total_reg + TOT_W'(size_eff);
                        if (size_eff == '0) begin
                            empty_id_next[empty_cnt_reg[IDX_W-1:0]] =
                                ID_W'(dev_cnt_reg[IDX_W-1:0]);
                            empty_cnt_next = empty_cnt_reg + 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        state_next    = S_WAIT;
                        div_start     = 1'b1;
                        wait_cnt_next = '0;
                    end
                end
            end
            S_WAIT: begin
                if (wait_cnt_reg != WAIT_W'(WAIT_N)) begin
                    wait_cnt_next = wait_cnt_reg + 1'b1;
                end else if (div_done) begin
                    if (ovf_reg || (empty_cnt_reg == '0) ||
                        (total_reg < TOT_W'(dev_cnt_reg))) begin
                        // One status beat closes the plan.
                        if (out_free) begin
                            emit          = 1'b1;
                            m_src_next    = '0;
                            m_dst_next    = '0;
                            m_amount_next = '0;
                            m_last_next   = 1'b1;
                            if (ovf_reg) begin
                                m_status_next = ST_TOOMANY;
                            end else if (empty_cnt_reg == '0) begin
                                m_status_next = ST_NOBAL;
                            end else begin
                                m_status_next = ST_SHORT;
                            end
                            chain_ctl.clr  = 1'b1;
                            dev_cnt_next   = '0;
                            empty_cnt_next = '0;
                            total_next     = '0;
                            ovf_next       = 1'b0;
                            state_next     = S_LOAD;
                        end
                    end else begin
                        // Take the largest device as the first source.
                        src_size_next   = held_size[0];
                        src_id_next     = ID_W'(held_idx[0]);
                        src_hi_next     = 1'b0;
                        src_pos_next    = '0;
                        full_next       = dev_cnt_reg - empty_cnt_reg;
                        dst_left_next   = empty_cnt_reg;
                        skip_next       = 1'b0;
                        chain_ctl.shift = 1'b1;
                        state_next      = S_PLAN;
                    end
                end
            end
            S_PLAN: begin
                if (out_free) begin
                    if (!skip_reg && src_low) begin
                        if (({1'b0, src_pos_reg} + 1'b1) >= {1'b0, full_reg}) begin
                            // The next source would be an empty device.
                            emit           = 1'b1;
                            m_status_next  = ST_SRC_MT;
                            m_src_next     = '0;
                            m_dst_next     = '0;
                            m_amount_next  = '0;
                            m_last_next    = 1'b1;
                            chain_ctl.clr  = 1'b1;
                            dev_cnt_next   = '0;
                            empty_cnt_next = '0;
                            total_next     = '0;
                            ovf_next       = 1'b0;
                            state_next     = S_LOAD;
                        end else begin
                            // Move on to the next ranked source; it is used without a check.
                            src_size_next   = held_size[0];
                            src_id_next     = ID_W'(held_idx[0]);
                            src_hi_next     = 1'b0;
                            src_pos_next    = src_pos_reg + 1'b1;
                            skip_next       = 1'b1;
                            chain_ctl.shift = 1'b1;
                        end
                    end else begin
                        emit          = 1'b1;
                        m_status_next = ST_XFER;
                        m_src_next    = src_id_reg;
                        m_dst_next    = empty_id_reg[0];
                        m_amount_next = AMT_W'(quota);
                        m_last_next   = (dst_left_reg == CNT_W'(1));
                        src_size_next = src_diff[EFF_W-1:0];
                        src_hi_next   = src_hi_reg || src_diff[EFF_W];
                        dst_left_next = dst_left_reg - 1'b1;
                        skip_next     = 1'b0;
                        for (int i = 0; i < N - 1; i++) begin
                            empty_id_next[i] = empty_id_reg[i+1];
                        end
                        if (dst_left_reg == CNT_W'(1)) begin
                            chain_ctl.clr  = 1'b1;
                            dev_cnt_next   = '0;
                            empty_cnt_next = '0;
                            total_next     = '0;
                            ovf_next       = 1'b0;
                            state_next     = S_LOAD;
                        end
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            dev_cnt_reg   <= '0;
            empty_cnt_reg <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            wait_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dev_cnt_reg   <= dev_cnt_next;
            empty_cnt_reg <= empty_cnt_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            wait_cnt_reg  <= wait_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        empty_id_reg <= empty_id_next;
        src_size_reg <= src_size_next;
        src_hi_reg   <= src_hi_next;
        src_id_reg   <= src_id_next;
        src_pos_reg  <= src_pos_next;
        full_reg     <= full_next;
        dst_left_reg <= dst_left_next;
        skip_reg     <= skip_next;
        m_status_reg <= m_status_next;
        m_src_reg    <= m_src_next;
        m_dst_reg    <= m_dst_next;
        m_amount_reg <= m_amount_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_src_device  = m_src_reg;
    assign m_dst_device  = m_dst_reg;
    assign m_amount      = m_amount_reg;
    assign m_last_result = m_last_reg;

endmodule

### src/bbp_cell.sv
// One cell of the systolic ranking chain: holds one device and forwards the rest.
`timescale 1ns / 1ps

module bbp_cell #(
    parameter int SIZE_W = 16,
    parameter int IDX_W  = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbp_pkg::cell_ctl_t ctl,
    input  logic              in_v,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [IDX_W-1:0]  in_idx,
    input  logic              nxt_v,
    input  logic [SIZE_W-1:0] nxt_size,
    input  logic [IDX_W-1:0]  nxt_idx,
    output logic              pass_v,
    output logic [SIZE_W-1:0] pass_size,
    output logic [IDX_W-1:0]  pass_idx,
    output logic              held_v,
    output logic [SIZE_W-1:0] held_size,
    output logic [IDX_W-1:0]  held_idx
);
    import bbp_pkg::*;

    logic              held_v_reg, held_v_next;
    logic [SIZE_W-1:0] held_size_reg, held_size_next;
    logic [IDX_W-1:0]  held_idx_reg, held_idx_next;
    logic              pass_v_reg, pass_v_next;
    logic [SIZE_W-1:0] pass_size_reg, pass_size_next;
    logic [IDX_W-1:0]  pass_idx_reg, pass_idx_next;
    logic              take;

    // The newcomer wins on a larger size, or on an equal size if it arrived earlier.
    assign take = in_v && (!held_v_reg || (in_size > held_size_reg) ||
                  ((in_size == held_size_reg) && (in_idx < held_idx_reg)));

    always_comb begin
        held_v_next    = held_v_reg;
        held_size_next = held_size_reg;
        held_idx_next  = held_idx_reg;
        pass_v_next    = 1'b0;
        pass_size_next = in_size;
        pass_idx_next  = in_idx;
        if (ctl.clr) begin
            held_v_next = 1'b0;
        end else if (ctl.shift) begin
            held_v_next    = nxt_v;
            held_size_next = nxt_size;
            held_idx_next  = nxt_idx;
        end else if (take) begin
            held_v_next    = 1'b1;
            held_size_next = in_size;
            held_idx_next  = in_idx;
            pass_v_next    = held_v_reg;
            pass_size_next = held_size_reg;
            pass_idx_next  = held_idx_reg;
        end else begin
            pass_v_next = in_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_v_reg <= 1'b0;
            pass_v_reg <= 1'b0;
        end else begin
            held_v_reg <= held_v_next;
            pass_v_reg <= pass_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_size_reg <= held_size_next;
        held_idx_reg  <= held_idx_next;
        pass_size_reg <= pass_size_next;
        pass_idx_reg  <= pass_idx_next;
    end

    assign pass_v    = pass_v_reg;
    assign pass_size = pass_size_reg;
    assign pass_idx  = pass_idx_reg;
    assign held_v    = held_v_reg;
    assign held_size = held_size_reg;
    assign held_idx  = held_idx_reg;

endmodule

### src/bbp_div.sv
// Restoring divider that works out one quotient bit per cycle.
`timescale 1ns / 1ps

module bbp_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### src/bbp_checker.sv
// Port-level checker of the batch balance planner, bound to its top level.
`timescale 1ns / 1ps
`include "batch_balance_planner_top_macros.svh"

module bbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [bbp_pkg::IN_SIZE_W-1:0] s_device_size,
    input logic                          s_last,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bbp_pkg::STATUS_W-1:0]  m_status,
    input logic [bbp_pkg::ID_W-1:0]      m_src_device,
    input logic [bbp_pkg::ID_W-1:0]      m_dst_device,
    input logic [bbp_pkg::AMT_W-1:0]     m_amount,
    input logic                          m_last_result
);
    import bbp_pkg::*;

    // A stalled result beat holds.
    `BBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_amount) && $stable(m_src_device) && $stable(m_dst_device) && $stable(m_last_result), "result beat changed while stalled")
    // Every status other than a transfer ends the plan.
    `BBP_ASSERT_SAME(a_status_last, aclk, aresetn, m_valid && (m_status != ST_XFER), m_last_result, "status beat without final mark")
    // No new set is loaded while a plan is still being produced.
    `BBP_ASSERT_SAME(a_plan_busy, aclk, aresetn, m_valid && (m_status == ST_XFER) && !m_last_result, !s_ready, "input taken during a plan")
    // A beat that is not final keeps the loader open.
    `BBP_ASSERT_NEXT(a_load_open, aclk, aresetn, s_valid && s_ready && !s_last, s_ready, "loader closed before final beat")

endmodule

bind batch_balance_planner_top bbp_checker u_bbp_checker (.*);
